// File: design/xesp_pkg.sv
`default_nettype none

package xesp_pkg;

	// width of the running tick time and the duration accumulator
	localparam int TIME_BITS = 32;

	// result queue depth; must leave room for two results per byte
	localparam int OUT_DEPTH = 4;
	localparam int OUT_PW    = $clog2(OUT_DEPTH);
	localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

	typedef logic [TIME_BITS-1:0] tick_t;

	// status nibbles and special bytes
	localparam logic [7:0] STATUS_MIN  = 8'h80;
	localparam logic [3:0] NIB_NOTEOFF = 4'h8;
	localparam logic [3:0] NIB_NOTEON  = 4'h9;
	localparam logic [3:0] NIB_AFTER   = 4'hA;
	localparam logic [3:0] NIB_CTRL    = 4'hB;
	localparam logic [3:0] NIB_PROG    = 4'hC;
	localparam logic [3:0] NIB_PRESS   = 4'hD;
	localparam logic [3:0] NIB_BEND    = 4'hE;
	localparam logic [7:0] META_STATUS = 8'hFF;
	localparam logic [7:0] META_TEMPO  = 8'h51;

	localparam logic KIND_NODE    = 1'b0;
	localparam logic KIND_PAYLOAD = 1'b1;

	// parse phases, one-hot
	typedef enum logic [7:0] {
		PH_IDLE      = 8'b0000_0001,
		PH_TWO_A     = 8'b0000_0010,
		PH_TWO_B     = 8'b0000_0100,
		PH_DUR       = 8'b0000_1000,
		PH_ONE       = 8'b0001_0000,
		PH_META_TYPE = 8'b0010_0000,
		PH_META_LEN  = 8'b0100_0000,
		PH_META_DATA = 8'b1000_0000
	} phase_t;

	// one result beat
	typedef struct packed {
		logic [31:0] event_time;
		logic [31:0] event_index;
		logic [7:0]  status_byte;
		logic [7:0]  first_data;
		logic [7:0]  second_data;
		logic        kind;
		logic [7:0]  payload_byte;
		logic [31:0] tempo_value;
		logic        last;
	} result_t;

	function automatic result_t make_result(input tick_t t, input logic [31:0] idx,
			input logic [7:0] st, input logic [7:0] d1, input logic [7:0] d2,
			input logic k, input logic [7:0] pb);
		result_t r;
		r              = '0;
		r.event_time   = 32'(t);
		r.event_index  = idx;
		r.status_byte  = st;
		r.first_data   = d1;
		r.second_data  = d2;
		r.kind         = k;
		r.payload_byte = pb;
		return r;
	endfunction

endpackage

`default_nettype wire

// File: design/xesp_parser.sv
`default_nettype none

module xesp_parser (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             fire,
	input  wire logic [7:0]       byte_s1,
	input  wire logic             start_s1,
	output xesp_pkg::result_t     res0,
	output xesp_pkg::result_t     res1,
	output logic [1:0]            res_count
);

	xesp_pkg::phase_t phase_q, phase_e, phase_n;
	xesp_pkg::tick_t  time_q, time_e, time_n;
	xesp_pkg::tick_t  dur_q, dur_e, dur_n, acc;
	logic [31:0]      cnt_q, cnt_e, cnt_n;
	logic [7:0]       status_q, status_n;
	logic [7:0]       first_q, first_n;
	logic [7:0]       second_q, second_n;
	logic [7:0]       left_q, left_e, left_n;
	logic [31:0]      tempo_q, tempo_n;
	logic             cap_q, cap_e, cap_n;

	// chunk start restarts everything but the held bytes and the tempo
	always_comb begin
		if (start_s1) begin
			phase_e = xesp_pkg::PH_IDLE;
			time_e  = '0;
			cnt_e   = '0;
			dur_e   = '0;
			left_e  = '0;
			cap_e   = 1'b0;
		end else begin
			phase_e = phase_q;
			time_e  = time_q;
			cnt_e   = cnt_q;
			dur_e   = dur_q;
			left_e  = left_q;
			cap_e   = cap_q;
		end
	end

	// duration groups, big end first
	assign acc = xesp_pkg::tick_t'({dur_e, byte_s1[6:0]});

	// next state and results for the byte in the input register
	always_comb begin
		phase_n   = phase_e;
		time_n    = time_e;
		cnt_n     = cnt_e;
		dur_n     = dur_e;
		left_n    = left_e;
		cap_n     = cap_e;
		status_n  = status_q;
		first_n   = first_q;
		second_n  = second_q;
		tempo_n   = tempo_q;
		res_count = 2'd0;
		res0      = '0;
		res1      = '0;
		unique case (phase_e)
			xesp_pkg::PH_IDLE: begin
				if (byte_s1 < xesp_pkg::STATUS_MIN) begin
					time_n = time_e + xesp_pkg::tick_t'(byte_s1);
				end else begin
					status_n = byte_s1;
					first_n  = '0;
					second_n = '0;
					unique case (byte_s1[7:4])
						xesp_pkg::NIB_NOTEOFF, xesp_pkg::NIB_NOTEON, xesp_pkg::NIB_AFTER,
						xesp_pkg::NIB_CTRL, xesp_pkg::NIB_BEND: begin
							phase_n = xesp_pkg::PH_TWO_A;
						end
						xesp_pkg::NIB_PROG, xesp_pkg::NIB_PRESS: begin
							phase_n = xesp_pkg::PH_ONE;
						end
						default: begin
							if (byte_s1 == xesp_pkg::META_STATUS) begin
								phase_n = xesp_pkg::PH_META_TYPE;
							end else begin
								// other system status goes out at once
								res0 = xesp_pkg::make_result(time_e, cnt_e, byte_s1,
									8'd0, 8'd0, xesp_pkg::KIND_NODE, 8'd0);
								res_count = 2'd1;
								cnt_n     = cnt_e + 32'd1;
							end
						end
					endcase
				end
			end
			xesp_pkg::PH_TWO_A: begin
				first_n = byte_s1;
				phase_n = xesp_pkg::PH_TWO_B;
			end
			xesp_pkg::PH_TWO_B: begin
				second_n  = byte_s1;
				res0      = xesp_pkg::make_result(time_e, cnt_e, status_q, first_q,
					byte_s1, xesp_pkg::KIND_NODE, 8'd0);
				res_count = 2'd1;
				cnt_n     = cnt_e + 32'd1;
				if (status_q[7:4] == xesp_pkg::NIB_NOTEON) begin
					dur_n   = '0;
					phase_n = xesp_pkg::PH_DUR;
				end else begin
					phase_n = xesp_pkg::PH_IDLE;
				end
			end
			xesp_pkg::PH_DUR: begin
				dur_n = acc;
				if (!byte_s1[7]) begin
					// matching note-off as a zero-velocity note-on
					res0      = xesp_pkg::make_result(time_e + acc, cnt_e, status_q,
						first_q, 8'd0, xesp_pkg::KIND_NODE, 8'd0);
					res_count = 2'd1;
					cnt_n     = cnt_e + 32'd1;
					phase_n   = xesp_pkg::PH_IDLE;
				end
			end
			xesp_pkg::PH_ONE: begin
				first_n   = byte_s1;
				res0      = xesp_pkg::make_result(time_e, cnt_e, status_q, byte_s1,
					8'd0, xesp_pkg::KIND_NODE, 8'd0);
				res_count = 2'd1;
				cnt_n     = cnt_e + 32'd1;
				phase_n   = xesp_pkg::PH_IDLE;
			end
			xesp_pkg::PH_META_TYPE: begin
				first_n = byte_s1;
				phase_n = xesp_pkg::PH_META_LEN;
			end
			xesp_pkg::PH_META_LEN: begin
				second_n = byte_s1;
				left_n   = byte_s1;
				cap_n    = (first_q == xesp_pkg::META_TEMPO) && (tempo_q == 32'd0);
				if (byte_s1 == 8'd0) begin
					res0      = xesp_pkg::make_result(time_e, cnt_e, status_q, first_q,
						8'd0, xesp_pkg::KIND_NODE, 8'd0);
					res_count = 2'd1;
					cnt_n     = cnt_e + 32'd1;
					phase_n   = xesp_pkg::PH_IDLE;
				end else begin
					phase_n = xesp_pkg::PH_META_DATA;
				end
			end
			xesp_pkg::PH_META_DATA: begin
				if (cap_e) begin
					tempo_n = {tempo_q[23:0], byte_s1};
				end
				res0      = xesp_pkg::make_result(time_e, cnt_e, status_q, first_q,
					second_q, xesp_pkg::KIND_PAYLOAD, byte_s1);
				res_count = 2'd1;
				left_n    = left_e - 8'd1;
				if (left_n == 8'd0) begin
					// meta node follows its last payload beat, same index
					res1      = xesp_pkg::make_result(time_e, cnt_e, status_q, first_q,
						second_q, xesp_pkg::KIND_NODE, 8'd0);
					res_count = 2'd2;
					cnt_n     = cnt_e + 32'd1;
					cap_n     = 1'b0;
					phase_n   = xesp_pkg::PH_IDLE;
				end
			end
			default: begin
				phase_n = xesp_pkg::PH_IDLE;
			end
		endcase
		res0.tempo_value = tempo_n;
		res1.tempo_value = tempo_n;
		res0.last        = (res_count == 2'd1);
		res1.last        = (res_count == 2'd2);
	end

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= xesp_pkg::PH_IDLE;
			time_q   <= '0;
			cnt_q    <= '0;
			dur_q    <= '0;
			left_q   <= '0;
			cap_q    <= 1'b0;
			status_q <= '0;
			first_q  <= '0;
			second_q <= '0;
			tempo_q  <= '0;
		end else if (fire) begin
			phase_q  <= phase_n;
			time_q   <= time_n;
			cnt_q    <= cnt_n;
			dur_q    <= dur_n;
			left_q   <= left_n;
			cap_q    <= cap_n;
			status_q <= status_n;
			first_q  <= first_n;
			second_q <= second_n;
			tempo_q  <= tempo_n;
		end
	end

endmodule

`default_nettype wire

// File: design/xesp_out_fifo.sv
`default_nettype none

module xesp_out_fifo (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [1:0]                  push_count,
	input  wire xesp_pkg::result_t           push0,
	input  wire xesp_pkg::result_t           push1,
	input  wire logic                        pop,
	output xesp_pkg::result_t                head,
	output logic [xesp_pkg::OUT_CW-1:0]      count,
	output logic                             room_for_two
);

	xesp_pkg::result_t               mem_q [xesp_pkg::OUT_DEPTH];
	logic [xesp_pkg::OUT_PW-1:0]     wr_ptr_q, rd_ptr_q, wr_ptr1;
	logic [xesp_pkg::OUT_CW-1:0]     count_q;

	assign wr_ptr1      = wr_ptr_q + xesp_pkg::OUT_PW'(1);
	assign head         = mem_q[rd_ptr_q];
	assign count        = count_q;
	assign room_for_two = count_q <= xesp_pkg::OUT_CW'(xesp_pkg::OUT_DEPTH - 2);

	// storage: up to two beats written per cycle
	always_ff @(posedge clk) begin
		if (push_count != 2'd0) begin
			mem_q[wr_ptr_q] <= push0;
		end
		if (push_count == 2'd2) begin
			mem_q[wr_ptr1] <= push1;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + xesp_pkg::OUT_PW'(push_count);
			rd_ptr_q <= rd_ptr_q + xesp_pkg::OUT_PW'(pop);
			count_q  <= count_q + xesp_pkg::OUT_CW'(push_count) - xesp_pkg::OUT_CW'(pop);
		end
	end

endmodule

`default_nettype wire

// File: design/xmi_event_stream_parser_unit.sv
// XMI event stream parser.
// Input channel: one raw byte of an EVNT chunk per beat (byte_in), with
// chunk_start high on the first byte of a chunk; it restarts time, index and
// parsing but keeps the captured tempo.
// Output channel: one result per beat, either an event node (kind 0) or a
// meta payload byte (kind 1); last marks the final result of an input byte.
// A byte yields zero, one or two results (two only for the last payload byte
// of a meta event, which is followed by the meta node).
// A byte is taken into an input register and parsed from there into the
// result queue, from whose head its first result is then offered.
// Throughput: one byte per cycle; the byte sits in an input register and is
// parsed in a single pass into a four-beat result queue, which takes a byte
// whenever it has room for two beats.
// Reset: the queue empties, the parser goes idle with time, index and tempo
// at zero.
// Receiver stall: results wait in the queue; once it has fewer than two free
// slots a byte in the input register is held and in_ready falls.
`default_nettype none

module xmi_event_stream_parser_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  byte_in,
	input  wire logic        chunk_start,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      event_time,
	output logic [31:0]      event_index,
	output logic [7:0]       status_byte,
	output logic [7:0]       first_data,
	output logic [7:0]       second_data,
	output logic             kind,
	output logic [7:0]       payload_byte,
	output logic [31:0]      tempo_value,
	output logic             last
);

	logic                            valid_s1, fire, room_for_two, pop;
	logic [7:0]                      byte_s1;
	logic                            start_s1;
	logic [1:0]                      res_count, push_count;
	logic [xesp_pkg::OUT_CW-1:0]     fill;
	xesp_pkg::result_t               res0, res1, head;

	assign fire     = valid_s1 && room_for_two;
	assign in_ready = !valid_s1 || fire;
	assign pop      = out_valid && out_ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1  <= byte_in;
			start_s1 <= chunk_start;
		end
	end

	xesp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.byte_s1   (byte_s1),
		.start_s1  (start_s1),
		.res0      (res0),
		.res1      (res1),
		.res_count (res_count)
	);

	assign push_count = fire ? res_count : 2'd0;

	xesp_out_fifo u_out_fifo (
		.clk          (clk),
		.arst_n       (arst_n),
		.push_count   (push_count),
		.push0        (res0),
		.push1        (res1),
		.pop          (pop),
		.head         (head),
		.count        (fill),
		.room_for_two (room_for_two)
	);

	// result beat
	assign out_valid    = fill != '0;
	assign event_time   = head.event_time;
	assign event_index  = head.event_index;
	assign status_byte  = head.status_byte;
	assign first_data   = head.first_data;
	assign second_data  = head.second_data;
	assign kind         = head.kind;
	assign payload_byte = head.payload_byte;
	assign tempo_value  = head.tempo_value;
	assign last         = head.last;

`ifndef ASSERT_OFF
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill <= xesp_pkg::OUT_CW'(xesp_pkg::OUT_DEPTH))
		else $error("result queue overfilled");

	a_pair_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && res_count == 2'd2) |-> (res0.kind == xesp_pkg::KIND_PAYLOAD) &&
		(res1.kind == xesp_pkg::KIND_NODE) && !res0.last && res1.last &&
		(res0.event_index == res1.event_index))
		else $error("double result is not payload then meta node");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !fire) |=> valid_s1 && $stable(byte_s1) && $stable(start_s1))
		else $error("stalled input register changed");
`endif

endmodule

`default_nettype wire

// File: tb/xmi_event_stream_parser_unit_tb.sv
`default_nettype none

module xmi_event_stream_parser_unit_tb;

	localparam int DIR_ROWS     = 33;
	localparam int RANDOM_BYTES = 1750;
	localparam int MODE_SPAN    = 200;
	localparam int HOLD_AT      = 800;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_LIMIT  = 20000;
	localparam int SETTLE       = 8;

	// one row of the directed table; the typed rows carry their single event node
	typedef struct packed {
		logic [7:0]  b;
		logic        cs;
		logic        typed;
		logic [31:0] t;
		logic [31:0] idx;
		logic [7:0]  st;
		logic [7:0]  d1;
		logic [7:0]  d2;
	} row_t;

	typedef struct packed {
		logic [7:0] b;
		logic       cs;
	} beat_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  byte_in;
	logic        chunk_start;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] event_time;
	logic [31:0] event_index;
	logic [7:0]  status_byte;
	logic [7:0]  first_data;
	logic [7:0]  second_data;
	logic        kind;
	logic [7:0]  payload_byte;
	logic [31:0] tempo_value;
	logic        last;

	xmi_event_stream_parser_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.byte_in      (byte_in),
		.chunk_start  (chunk_start),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.event_time   (event_time),
		.event_index  (event_index),
		.status_byte  (status_byte),
		.first_data   (first_data),
		.second_data  (second_data),
		.kind         (kind),
		.payload_byte (payload_byte),
		.tempo_value  (tempo_value),
		.last         (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// stimulus, expectations and run statistics
	row_t              directed_rows [DIR_ROWS];
	beat_t             chunk_bytes [$];
	xesp_pkg::result_t due_events [$];
	xesp_pkg::result_t step_results [$];
	int                mismatches      = 0;
	int                bytes_taken     = 0;
	int                results_checked = 0;
	int                payload_results = 0;
	int                in_stall_cycles = 0;
	int                stall_pct       = 0;
	bit                hold_req        = 1'b0;
	bit                hold_done       = 1'b0;

	// parser state as the predictor sees it
	xesp_pkg::phase_t ph;
	xesp_pkg::tick_t  run_time;
	logic [31:0]      ev_count;
	logic [7:0]       cur_status;
	logic [7:0]       cur_first;
	logic [7:0]       cur_second;
	xesp_pkg::tick_t  dur_acc;
	logic [7:0]       bytes_left;
	logic [31:0]      tempo;
	logic             tempo_grab;

	function automatic row_t plain(input logic [7:0] b, input logic cs);
		row_t r;
		r    = '0;
		r.b  = b;
		r.cs = cs;
		return r;
	endfunction

	function automatic row_t known(input logic [7:0] b, input logic [31:0] t,
			input logic [31:0] idx, input logic [7:0] st, input logic [7:0] d1,
			input logic [7:0] d2);
		row_t r;
		r       = '0;
		r.b     = b;
		r.typed = 1'b1;
		r.t     = t;
		r.idx   = idx;
		r.st    = st;
		r.d1    = d1;
		r.d2    = d2;
		return r;
	endfunction

	task automatic add_beat(input logic [7:0] b, input logic cs);
		beat_t x;
		x.b         = b;
		x.cs        = cs;
		chunk_bytes = {chunk_bytes, x};
	endtask

	// one well-formed event with random content, or now and then noise or a torn event
	task automatic queue_random_event();
		int         roll;
		int         n;
		logic [7:0] st;
		logic       lead_cs;
		roll    = $urandom_range(99, 0);
		lead_cs = ($urandom_range(19, 0) == 0);
		if (roll < 6) begin
			n = $urandom_range(3, 1);
			repeat (n) add_beat(8'($urandom_range(255, 0)), 1'b0);
		end else if (roll < 10) begin
			// status and part of its data, then a chunk restart mid-event
			add_beat(8'($urandom_range(255, 128)), 1'b0);
			n = $urandom_range(2, 0);
			repeat (n) add_beat(8'($urandom_range(255, 0)), 1'b0);
			add_beat(8'($urandom_range(255, 0)), 1'b1);
		end else begin
			n = $urandom_range(2, 0);
			repeat (n) begin
				add_beat(8'($urandom_range(127, 0)), lead_cs);
				lead_cs = 1'b0;
			end
			roll = $urandom_range(99, 0);
			if (roll < 55) begin
				case ($urandom_range(5, 0))
					0:       st = {xesp_pkg::NIB_NOTEOFF, 4'($urandom_range(15, 0))};
					1:       st = {xesp_pkg::NIB_AFTER, 4'($urandom_range(15, 0))};
					2:       st = {xesp_pkg::NIB_CTRL, 4'($urandom_range(15, 0))};
					3:       st = {xesp_pkg::NIB_BEND, 4'($urandom_range(15, 0))};
					default: st = {xesp_pkg::NIB_NOTEON, 4'($urandom_range(15, 0))};
				endcase
				add_beat(st, lead_cs);
				add_beat(8'($urandom_range(255, 0)), 1'b0);
				add_beat(8'($urandom_range(255, 0)), 1'b0);
				if (st[7:4] == xesp_pkg::NIB_NOTEON) begin
					// duration: continuation groups first, up to five groups
					n = $urandom_range(5, 1);
					repeat (n - 1) add_beat({1'b1, 7'($urandom_range(127, 0))}, 1'b0);
					add_beat({1'b0, 7'($urandom_range(127, 0))}, 1'b0);
				end
			end else if (roll < 70) begin
				st = {($urandom_range(1, 0) == 1) ? xesp_pkg::NIB_PROG : xesp_pkg::NIB_PRESS,
					4'($urandom_range(15, 0))};
				add_beat(st, lead_cs);
				add_beat(8'($urandom_range(255, 0)), 1'b0);
			end else if (roll < 80) begin
				add_beat(8'($urandom_range(254, 240)), lead_cs);
			end else begin
				add_beat(xesp_pkg::META_STATUS, lead_cs);
				add_beat(($urandom_range(99, 0) < 35) ? xesp_pkg::META_TEMPO :
					8'($urandom_range(255, 0)), 1'b0);
				n = ($urandom_range(99, 0) < 3) ? $urandom_range(255, 0) :
					$urandom_range(6, 0);
				add_beat(8'(n), 1'b0);
				repeat (n) add_beat(8'($urandom_range(255, 0)), 1'b0);
			end
		end
	endtask

	task automatic push_beat(input xesp_pkg::tick_t t, input logic [31:0] idx,
			input logic [7:0] st, input logic [7:0] d1, input logic [7:0] d2,
			input logic k, input logic [7:0] pb);
		xesp_pkg::result_t r;
		r              = '0;
		r.event_time   = t;
		r.event_index  = idx;
		r.status_byte  = st;
		r.first_data   = d1;
		r.second_data  = d2;
		r.kind         = k;
		r.payload_byte = pb;
		step_results   = {step_results, r};
	endtask

	task automatic push_node(input xesp_pkg::tick_t t, input logic [7:0] d1,
			input logic [7:0] d2);
		push_beat(t, ev_count, cur_status, d1, d2, xesp_pkg::KIND_NODE, 8'h00);
		ev_count++;
	endtask

	// predicts the results of one accepted byte into step_results
	task automatic parse_byte(input logic [7:0] b, input logic cs);
		step_results.delete();
		if (cs) begin
			ph         = xesp_pkg::PH_IDLE;
			run_time   = '0;
			ev_count   = '0;
			dur_acc    = '0;
			bytes_left = '0;
			tempo_grab = 1'b0;
		end
		case (ph)
			xesp_pkg::PH_IDLE: begin
				if (b < xesp_pkg::STATUS_MIN) begin
					run_time = run_time + xesp_pkg::tick_t'(b);
				end else begin
					cur_status = b;
					cur_first  = '0;
					cur_second = '0;
					case (b[7:4])
						xesp_pkg::NIB_NOTEOFF, xesp_pkg::NIB_NOTEON, xesp_pkg::NIB_AFTER,
						xesp_pkg::NIB_CTRL, xesp_pkg::NIB_BEND: ph = xesp_pkg::PH_TWO_A;
						xesp_pkg::NIB_PROG, xesp_pkg::NIB_PRESS: ph = xesp_pkg::PH_ONE;
						default: begin
							if (b == xesp_pkg::META_STATUS)
								ph = xesp_pkg::PH_META_TYPE;
							else
								push_node(run_time, 8'h00, 8'h00);
						end
					endcase
				end
			end
			xesp_pkg::PH_TWO_A: begin
				cur_first = b;
				ph        = xesp_pkg::PH_TWO_B;
			end
			xesp_pkg::PH_TWO_B: begin
				cur_second = b;
				push_node(run_time, cur_first, cur_second);
				if (cur_status[7:4] == xesp_pkg::NIB_NOTEON) begin
					dur_acc = '0;
					ph      = xesp_pkg::PH_DUR;
				end else begin
					ph = xesp_pkg::PH_IDLE;
				end
			end
			xesp_pkg::PH_DUR: begin
				dur_acc = (dur_acc << 7) | xesp_pkg::tick_t'(b[6:0]);
				if (!b[7]) begin
					// matching note-off as velocity-zero note-on
					push_node(run_time + dur_acc, cur_first, 8'h00);
					ph = xesp_pkg::PH_IDLE;
				end
			end
			xesp_pkg::PH_ONE: begin
				cur_first = b;
				push_node(run_time, cur_first, 8'h00);
				ph = xesp_pkg::PH_IDLE;
			end
			xesp_pkg::PH_META_TYPE: begin
				cur_first = b;
				ph        = xesp_pkg::PH_META_LEN;
			end
			xesp_pkg::PH_META_LEN: begin
				cur_second = b;
				bytes_left = b;
				tempo_grab = (cur_first == xesp_pkg::META_TEMPO) && (tempo == '0);
				if (b == 8'h00) begin
					push_node(run_time, cur_first, 8'h00);
					ph = xesp_pkg::PH_IDLE;
				end else begin
					ph = xesp_pkg::PH_META_DATA;
				end
			end
			default: begin
				if (tempo_grab)
					tempo = {tempo[23:0], b};
				push_beat(run_time, ev_count, cur_status, cur_first, cur_second,
					xesp_pkg::KIND_PAYLOAD, b);
				bytes_left--;
				if (bytes_left == 8'h00) begin
					push_node(run_time, cur_first, cur_second);
					tempo_grab = 1'b0;
					ph         = xesp_pkg::PH_IDLE;
				end
			end
		endcase
		foreach (step_results[i])
			step_results[i].tempo_value = tempo;
		if (step_results.size() > 0)
			step_results[step_results.size() - 1].last = 1'b1;
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected 0x%h, got 0x%h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// input beats feed the predictor, output beats are checked in order
	always @(posedge clk) begin : watch
		xesp_pkg::result_t want;
		if (arst_n && in_valid && !in_ready)
			in_stall_cycles++;
		if (arst_n && in_valid && in_ready) begin
			parse_byte(byte_in, chunk_start);
			if (bytes_taken < DIR_ROWS && directed_rows[bytes_taken].typed) begin
				want             = '0;
				want.event_time  = directed_rows[bytes_taken].t;
				want.event_index = directed_rows[bytes_taken].idx;
				want.status_byte = directed_rows[bytes_taken].st;
				want.first_data  = directed_rows[bytes_taken].d1;
				want.second_data = directed_rows[bytes_taken].d2;
				want.kind        = xesp_pkg::KIND_NODE;
				want.last        = 1'b1;
				due_events       = {due_events, want};
			end else begin
				foreach (step_results[i])
					due_events = {due_events, step_results[i]};
			end
			bytes_taken++;
		end
		if (arst_n && out_valid && out_ready) begin
			if (due_events.size() == 0) begin
				$display("%0t: result with nothing expected, status 0x%h index %0d",
					$time, status_byte, event_index);
				mismatches++;
			end else begin
				want = due_events.pop_front();
				compare_field("event_time", want.event_time, event_time);
				compare_field("event_index", want.event_index, event_index);
				compare_field("status_byte", 32'(want.status_byte), 32'(status_byte));
				compare_field("first_data", 32'(want.first_data), 32'(first_data));
				compare_field("second_data", 32'(want.second_data), 32'(second_data));
				compare_field("kind", 32'(want.kind), 32'(kind));
				compare_field("payload_byte", 32'(want.payload_byte), 32'(payload_byte));
				compare_field("tempo_value", want.tempo_value, tempo_value);
				compare_field("last", 32'(want.last), 32'(last));
			end
			results_checked++;
			if (kind === xesp_pkg::KIND_PAYLOAD)
				payload_results++;
		end
	end

	// receiver: random stalls per mode, plus one long hold-off to fill the block
	initial begin : receiver
		int hold_count;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				out_ready <= 1'b0;
				hold_count = 0;
				while (hold_count < HOLD_CYCLES) begin
					@(posedge clk);
					hold_count++;
				end
				hold_done = 1'b1;
			end
			out_ready <= ($urandom_range(99, 0) >= stall_pct);
		end
	end

	// reset, sender and end of run
	initial begin : sender
		int pos;
		int gap_pct;
		int drain;
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		byte_in     <= 8'h00;
		chunk_start <= 1'b0;

		ph         = xesp_pkg::PH_IDLE;
		run_time   = '0;
		ev_count   = '0;
		cur_status = '0;
		cur_first  = '0;
		cur_second = '0;
		dur_acc    = '0;
		bytes_left = '0;
		tempo      = '0;
		tempo_grab = 1'b0;

		// directed: extremes, every status family, zero-payload tempo, empty meta, abort
		directed_rows = '{
			plain(8'h7F, 1'b1),
			known(8'hF0, 32'd127, 32'd0, 8'hF0, 8'h00, 8'h00),
			plain(8'h90, 1'b0), plain(8'h3C, 1'b0),
			known(8'hFF, 32'd127, 32'd1, 8'h90, 8'h3C, 8'hFF),
			plain(8'h81, 1'b0),
			known(8'h00, 32'd255, 32'd2, 8'h90, 8'h3C, 8'h00),
			plain(8'hC5, 1'b0),
			known(8'h80, 32'd127, 32'd3, 8'hC5, 8'h80, 8'h00),
			plain(8'hD0, 1'b0), plain(8'h00, 1'b0),
			plain(8'h8F, 1'b0), plain(8'h40, 1'b0), plain(8'h7F, 1'b0),
			plain(8'hAF, 1'b0), plain(8'h01, 1'b0), plain(8'h02, 1'b0),
			plain(8'hBF, 1'b0), plain(8'h07, 1'b0), plain(8'h64, 1'b0),
			plain(8'hEF, 1'b0), plain(8'h00, 1'b0), plain(8'h40, 1'b0),
			plain(8'hFF, 1'b0), plain(8'h51, 1'b0), plain(8'h01, 1'b0), plain(8'h00, 1'b0),
			plain(8'hFF, 1'b0), plain(8'h2F, 1'b0),
			known(8'h00, 32'd127, 32'd10, 8'hFF, 8'h2F, 8'h00),
			plain(8'h90, 1'b0), plain(8'h00, 1'b1),
			known(8'hFE, 32'd0, 32'd0, 8'hFE, 8'h00, 8'h00)
		};
		foreach (directed_rows[i])
			add_beat(directed_rows[i].b, directed_rows[i].cs);
		while (chunk_bytes.size() < DIR_ROWS + RANDOM_BYTES)
			queue_random_event();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		pos = 0;
		while (pos < chunk_bytes.size()) begin
			@(posedge clk);
			if (in_valid && in_ready)
				pos++;
			if (in_valid && !in_ready)
				continue;
			if (pos == HOLD_AT)
				hold_req = 1'b1;
			// idling modes rotate every MODE_SPAN bytes
			case ((pos / MODE_SPAN) % 4)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 59; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 59; end
				default: begin gap_pct = 38; stall_pct = 38; end
			endcase
			if (pos < chunk_bytes.size() && $urandom_range(99, 0) >= gap_pct) begin
				in_valid    <= 1'b1;
				byte_in     <= chunk_bytes[pos].b;
				chunk_start <= chunk_bytes[pos].cs;
			end else begin
				in_valid <= 1'b0;
			end
		end

		// let the last accepted byte reach the predictor before draining
		@(posedge clk);
		drain = 0;
		while (due_events.size() != 0 && drain < DRAIN_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		repeat (SETTLE) @(posedge clk);
		if (due_events.size() != 0) begin
			$display("%0t: %0d expected results never came out", $time, due_events.size());
			mismatches += due_events.size();
		end

		$display("Parsed %0d chunk bytes into %0d checked results, %0d of them meta payload.",
			bytes_taken, results_checked, payload_results);
		$display("Input held back on %0d cycles; tempo ended at 0x%h.", in_stall_cycles, tempo);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// watchdog
	initial begin
		#3000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire

// File: files.f
design/xesp_pkg.sv
design/xesp_parser.sv
design/xesp_out_fifo.sv
design/xmi_event_stream_parser_unit.sv
tb/xmi_event_stream_parser_unit_tb.sv
